[hdl/cbm_pkg.sv]
package cbm_pkg;

  // Default sizes of the cartridge.
  localparam int DEF_ROM_BANKS     = 32;
  localparam int DEF_RAM_BYTES_MAX = 32768;

  // Fixed layout of the CPU bus.
  localparam int BANK_SPAN_W = 14;  // one ROM bank spans 0x4000 bytes
  localparam int RAM_SPAN_W  = 13;  // the RAM window spans 0x2000 bytes

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [7:0] OPEN_BUS     = 8'hFF;
  localparam logic [3:0] RAM_KEY      = 4'hA;
  localparam logic [2:0] RAM_WINDOW   = 3'b101;  // 0xA000-0xBFFF

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_PRELOAD = 2'd2
  } op_t;

  // Write targets below 0x8000, selected by address bits 14:13.
  typedef enum logic [1:0] {
    REG_RAM_ENABLE = 2'd0,
    REG_LOW_BANK   = 2'd1,
    REG_UPPER_BANK = 2'd2,
    REG_MODE       = 2'd3
  } reg_sel_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_MASK  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_SIZE_BYTES = CFG_IDX_W'(1);

  // Where the byte of a result comes from.
  typedef enum logic [1:0] {
    SRC_OPEN = 2'd0,
    SRC_ROM  = 2'd1,
    SRC_RAM  = 2'd2
  } src_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [18:0] load_index;
  } access_t;

  typedef struct packed {
    logic [7:0] read_data;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  // Memory strobes and result source produced by the address decoder.
  typedef struct packed {
    logic rom_we;
    logic rom_re;
    logic ram_we;
    logic ram_re;
    src_t src;
  } mem_ctl_t;

endpackage

[hdl/cbm_chan_if.sv]
interface cbm_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hdl/cbm_ram.sv]
module cbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/cbm_ctrl.sv]
module cbm_ctrl
  import cbm_pkg::*;
#(
  parameter int ROM_BANKS     = DEF_ROM_BANKS,
  parameter int RAM_BYTES_MAX = DEF_RAM_BYTES_MAX,
  localparam int BANK_W = (ROM_BANKS > 1) ? $clog2(ROM_BANKS) : 1,
  localparam int ROM_AW = BANK_W + BANK_SPAN_W,
  localparam int RAM_AW = $clog2(RAM_BYTES_MAX)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  access_t           item,
  input  logic [6:0]        rom_bank_mask,
  input  logic [15:0]       ram_size_bytes,
  output mem_ctl_t          ctl,
  output logic [ROM_AW-1:0] rom_addr,
  output logic [RAM_AW-1:0] ram_addr
);

  localparam logic [6:0]  BANK_LIMIT_MASK = 7'(ROM_BANKS - 1);
  localparam logic [7:0]  BANK_COUNT      = 8'(ROM_BANKS);
  localparam int unsigned ROM_BYTES       = ROM_BANKS * (1 << BANK_SPAN_W);
  localparam logic [15:0] RAM_MAX16       = 16'(RAM_BYTES_MAX);

  logic       ram_enabled;
  logic [4:0] low_bank;
  logic [1:0] upper_bank;
  logic       advanced_mode;

  logic        is_read, is_write, is_preload;
  logic        in_rom, in_ram;
  logic [6:0]  bank, eff_bank;
  logic        rom_ok;
  logic [14:0] ram_off;
  logic [15:0] ram_limit;
  logic        ram_ok;
  logic        preload_ok;

  assign is_read    = (item.operation == OP_READ);
  assign is_write   = (item.operation == OP_WRITE);
  assign is_preload = (item.operation == OP_PRELOAD);

  assign in_rom = ~item.address[15];
  assign in_ram = (item.address[15:13] == RAM_WINDOW);

  // Banking registers, written by bus writes below 0x8000.
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enabled   <= 1'b0;
      low_bank      <= '0;
      upper_bank    <= '0;
      advanced_mode <= 1'b0;
    end else if (accept && is_write && in_rom) begin
      case (reg_sel_t'(item.address[14:13]))
        REG_RAM_ENABLE: ram_enabled   <= (item.write_data[3:0] == RAM_KEY);
        REG_LOW_BANK:   low_bank      <= item.write_data[4:0];
        REG_UPPER_BANK: upper_bank    <= item.write_data[1:0];
        REG_MODE:       advanced_mode <= item.write_data[0];
        default:        ram_enabled   <= ram_enabled;
      endcase
    end
  end

  always_comb begin
    if (!item.address[14]) begin
      bank = advanced_mode ? {upper_bank, 5'b0} : 7'b0;
    end else begin
      bank = {upper_bank, (low_bank == 5'd0) ? 5'd1 : low_bank};
    end
  end

  assign eff_bank = bank & rom_bank_mask & BANK_LIMIT_MASK;
  assign rom_ok   = ({1'b0, eff_bank} < BANK_COUNT);

  assign ram_off   = {2'b0, item.address[RAM_SPAN_W-1:0]}
                   + (advanced_mode ? {upper_bank, 13'b0} : 15'b0);
  assign ram_limit = (ram_size_bytes > RAM_MAX16) ? RAM_MAX16 : ram_size_bytes;
  assign ram_ok    = ram_enabled && in_ram && ({1'b0, ram_off} < ram_limit);

  assign preload_ok = (32'(item.load_index) < 32'(ROM_BYTES));

  always_comb begin
    ctl.rom_we = accept && is_preload && preload_ok;
    ctl.rom_re = accept && is_read && in_rom && rom_ok;
    ctl.ram_we = accept && is_write && ram_ok;
    ctl.ram_re = accept && is_read && ram_ok;
    if (is_read && in_rom && rom_ok) begin
      ctl.src = SRC_ROM;
    end else if (is_read && ram_ok) begin
      ctl.src = SRC_RAM;
    end else begin
      ctl.src = SRC_OPEN;
    end
  end

  assign rom_addr = is_preload ? ROM_AW'(item.load_index)
                               : {eff_bank[BANK_W-1:0], item.address[BANK_SPAN_W-1:0]};
  assign ram_addr = ram_off[RAM_AW-1:0];

endmodule

[hdl/cartridge_bank_mapper.sv]
// Bank-switching cartridge mapper.
// The access channel carries one bus transaction per item: a read, a write to
// the banking registers or external RAM, or a ROM preload byte. Every access
// transaction produces exactly one transaction on the result channel; writes,
// preloads and open-bus reads return 0xFF.
// The cfg channel writes the ROM bank mask (index 0) and the external RAM size
// in bytes (index 1). It is always ready and is meant to be used while idle.
// A result is registered in two steps after its access is accepted: stage
// one waits on the memory read, then the output register holds the result.
// Throughput is one access per cycle while the receiver is ready: ROM and
// external RAM sit in two synchronous memories with one write and one
// registered read port each; every access touches each memory at most once.
// After reset the block clears external RAM, one byte a cycle, holding
// access.ready low until all RAM_BYTES_MAX bytes (32768 by default) are cleared.
// ROM contents are not cleared and must be preloaded before they are read.
// When the receiver stalls, the output register holds its result, the
// in-flight read holds in the memory read register, and access.ready drops
// only once both stages are full.
module cartridge_bank_mapper
  import cbm_pkg::*;
#(
  parameter int ROM_BANKS     = DEF_ROM_BANKS,
  parameter int RAM_BYTES_MAX = DEF_RAM_BYTES_MAX
) (
  input logic       clk,
  input logic       rst,
  cbm_chan_if.sink   access,
  cbm_chan_if.source result,
  cbm_chan_if.sink   cfg
);

  localparam int BANK_W    = (ROM_BANKS > 1) ? $clog2(ROM_BANKS) : 1;
  localparam int ROM_AW    = BANK_W + BANK_SPAN_W;
  localparam int ROM_DEPTH = ROM_BANKS * (1 << BANK_SPAN_W);
  localparam int RAM_AW    = $clog2(RAM_BYTES_MAX);
  localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(RAM_BYTES_MAX - 1);

  // Configuration registers.
  logic [6:0]  rom_bank_mask;
  logic [15:0] ram_size_bytes;

  // RAM clearing pass after reset.
  logic              clr_busy;
  logic [RAM_AW-1:0] clr_addr;

  // Pipeline: stage one waits on the memory read, then the output register.
  logic       s1_valid;
  src_t       s1_src;
  logic       s1_adv;
  logic       o_valid;
  logic [7:0] o_data;
  logic       acc;

  mem_ctl_t          ctl;
  logic [ROM_AW-1:0] rom_addr;
  logic [RAM_AW-1:0] ram_addr;
  logic [7:0]        rom_rdata, ram_rdata;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;

  // Configuration writes are taken in every cycle; unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_mask  <= 7'd1;
      ram_size_bytes <= 16'd0;
    end else if (cfg.valid) begin
      if (cfg.payload.index == CFG_ROM_BANK_MASK) begin
        rom_bank_mask <= cfg.payload.data[6:0];
      end else if (cfg.payload.index == CFG_RAM_SIZE_BYTES) begin
        ram_size_bytes <= cfg.payload.data[15:0];
      end
    end
  end

  // Stage one moves into the output register whenever that register is empty
  // or being emptied; a new access enters when stage one is free or moving and no RAM clearing pass runs.
  assign s1_adv       = s1_valid && (!o_valid || result.ready);
  assign access.ready = !clr_busy && (!s1_valid || s1_adv);
  assign acc          = access.valid && access.ready;

  cbm_ctrl #(
    .ROM_BANKS     (ROM_BANKS),
    .RAM_BYTES_MAX (RAM_BYTES_MAX)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .accept         (acc),
    .item           (access.payload),
    .rom_bank_mask  (rom_bank_mask),
    .ram_size_bytes (ram_size_bytes),
    .ctl            (ctl),
    .rom_addr       (rom_addr),
    .ram_addr       (ram_addr)
  );

  // The read enable follows acceptance, so a stalled read result stays put
  // in the memory's read register until stage one moves on.
  cbm_ram #(
    .WIDTH (8),
    .DEPTH (ROM_DEPTH)
  ) u_rom (
    .clk   (clk),
    .we    (ctl.rom_we),
    .waddr (rom_addr),
    .wdata (access.payload.write_data),
    .re    (ctl.rom_re),
    .raddr (rom_addr),
    .rdata (rom_rdata)
  );

  // The clearing pass owns the RAM write port until it finishes; no access is
  // accepted meanwhile. A write and a later read of the same byte are accepted
  // in different cycles, so the read always sees the written value.
  assign ram_we    = clr_busy ? 1'b1 : ctl.ram_we;
  assign ram_waddr = clr_busy ? clr_addr : ram_addr;
  assign ram_wdata = clr_busy ? 8'd0 : access.payload.write_data;

  cbm_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES_MAX)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ctl.ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + RAM_AW'(1);
      if (clr_addr == CLR_LAST) begin
        clr_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_src <= ctl.src;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= 1'b1;
    end else if (result.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      case (s1_src)
        SRC_ROM: o_data <= rom_rdata;
        SRC_RAM: o_data <= ram_rdata;
        default: o_data <= OPEN_BUS;
      endcase
    end
  end

  assign result.valid             = o_valid;
  assign result.payload.read_data = o_data;

  // No access may enter while external RAM is being cleared.
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !access.ready)
    else $error("access accepted during RAM clearing pass");

  // The clearing pass never shares the RAM write port with a bus write.
  a_no_write_collision: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !ctl.ram_we)
    else $error("bus write to RAM during clearing pass");

  // An accepted access always lands in stage one.
  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    acc |=> s1_valid)
    else $error("accepted access lost before stage one");

  // A stage-one item that cannot advance is kept, along with its source.
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_src)))
    else $error("stalled stage-one item dropped or changed");

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cbm_pkg::*;

  // The block is built with its default sizes, so the shadow copy uses the same ones.
  localparam int ROM_BANKS   = DEF_ROM_BANKS;
  localparam int RAM_BYTES   = DEF_RAM_BYTES_MAX;
  localparam int BANK_SPAN   = 1 << BANK_SPAN_W;
  localparam int RAM_SPAN    = 1 << RAM_SPAN_W;
  localparam int ROM_BYTES   = ROM_BANKS * BANK_SPAN;
  localparam int MAX_REPORTS = 20;

  localparam logic [15:0] RAM_BASE      = {RAM_WINDOW, 13'd0};
  localparam logic [15:0] SWITCHED_BASE = 16'(BANK_SPAN);
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  // Shadow of the cartridge. It tracks the banking registers, the ROM bytes
  // that have been preloaded and the external RAM contents, predicts the byte
  // of every accepted access and keeps those bytes in order until the matching
  // result transaction arrives.
  class cart_scoreboard;
    logic [6:0]  bank_mask;
    logic [15:0] ram_size;
    logic        ram_on;
    logic [4:0]  low_bank;
    logic [1:0]  upper_bank;
    logic        bank_mode;
    logic [7:0]  rom_image [int unsigned];
    logic [13:0] bank_offsets [ROM_BANKS][$];
    logic [7:0]  ram_image [RAM_BYTES];
    logic [7:0]  expected_bytes [$];
    int unsigned compared, errors, n_read, n_write, n_load, n_unused;

    function new();
      bank_mask  = 7'd1;
      ram_size   = '0;
      ram_on     = 1'b0;
      low_bank   = '0;
      upper_bank = '0;
      bank_mode  = 1'b0;
      foreach (ram_image[i]) ram_image[i] = 8'h00;
    endfunction

    function void set_config(cfg_write_t w);
      case (w.index)
        CFG_ROM_BANK_MASK:  bank_mask = w.data[6:0];
        CFG_RAM_SIZE_BYTES: ram_size  = w.data;
        default: ;
      endcase
    endfunction

    // Bank selected for a CPU address below 0x8000 with the current registers.
    function logic [6:0] rom_bank(logic [15:0] addr);
      logic [6:0] bank;
      if (!addr[BANK_SPAN_W]) bank = bank_mode ? {upper_bank, 5'd0} : 7'd0;
      else bank = {upper_bank, (low_bank == 5'd0) ? 5'd1 : low_bank};
      return bank & bank_mask & 7'(ROM_BANKS - 1);
    endfunction

    function int unsigned rom_index(logic [15:0] addr);
      return {rom_bank(addr), addr[BANK_SPAN_W-1:0]};
    endfunction

    function bit rom_loaded(int unsigned idx);
      return rom_image.exists(idx);
    endfunction

    // Offset into external RAM for an address in the RAM window, and whether
    // the access reaches a byte that is enabled and fitted.
    function bit ram_slot(logic [15:0] addr, output int unsigned off);
      int unsigned limit;
      limit = (ram_size > RAM_BYTES) ? RAM_BYTES : ram_size;
      off = addr[RAM_SPAN_W-1:0];
      if (bank_mode) off += upper_bank * RAM_SPAN;
      return ram_on && limit != 0 && off < limit;
    endfunction

    function logic [7:0] predict_read_byte(access_t a);
      int unsigned idx;
      logic [7:0]  rd;
      rd = OPEN_BUS;
      case (a.operation)
        OP_READ: begin
          n_read++;
          if (!a.address[15]) rd = rom_image[rom_index(a.address)];
          else if (a.address[15:13] == RAM_WINDOW && ram_slot(a.address, idx))
            rd = ram_image[idx];
        end
        OP_WRITE: begin
          n_write++;
          if (!a.address[15]) begin
            case (reg_sel_t'(a.address[14:13]))
              REG_RAM_ENABLE: ram_on     = (a.write_data[3:0] == RAM_KEY);
              REG_LOW_BANK:   low_bank   = a.write_data[4:0];
              REG_UPPER_BANK: upper_bank = a.write_data[1:0];
              REG_MODE:       bank_mode  = a.write_data[0];
              default: ;
            endcase
          end else if (a.address[15:13] == RAM_WINDOW && ram_slot(a.address, idx)) begin
            ram_image[idx] = a.write_data;
          end
        end
        OP_PRELOAD: begin
          n_load++;
          idx = a.load_index;
          if (idx < ROM_BYTES) begin
            if (!rom_image.exists(idx))
              bank_offsets[idx / BANK_SPAN].push_back(idx[BANK_SPAN_W-1:0]);
            rom_image[idx] = a.write_data;
          end
        end
        default: n_unused++;
      endcase
      return rd;
    endfunction

    function void note_access(access_t a);
      expected_bytes.push_back(predict_read_byte(a));
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void check_result(result_t r);
      logic [7:0] exp_byte;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %02h", $time, r.read_data);
      end else begin
        exp_byte = expected_bytes.pop_front();
        compared++;
        if (r.read_data !== exp_byte) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: read_data mismatch, expected %02h, actual %02h",
                     $time, exp_byte, r.read_data);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  cbm_chan_if #(.payload_t(access_t))    access_ch ();
  cbm_chan_if #(.payload_t(result_t))    result_ch ();
  cbm_chan_if #(.payload_t(cfg_write_t)) cfg_ch ();

  cartridge_bank_mapper u_top (
    .clk   (clk),
    .rst   (rst),
    .access(access_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  cart_scoreboard sb = new();

  // Idle rates of the current phase, in percent, and a request for one long
  // hold-off of the result channel, counted in cycles by the receiver.
  int send_idle_pct;
  int stall_pct;
  int hold_request;
  int settings_used;
  logic [15:0] recent_ram_addr = RAM_BASE;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case the block hangs or drops results. The slowest correct
  // run, including the RAM clear after reset, is far below this.
  initial begin
    #1000000;
    $display("Timeout: results still outstanding: %0d", sb.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side. Every transaction is checked against the oldest predicted
  // byte. Ready is dropped at random at the phase's stall rate, and held low
  // for a long stretch when the stimulus asks for it, so the block backs up
  // into its input.
  initial begin
    int hold_left;
    hold_left = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) sb.check_result(result_ch.payload);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      result_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // Offers one access and returns at the edge where it is accepted. The
  // shadow is updated right there, so the next access is generated against
  // banking registers that already include this one.
  task automatic send_access(input logic [1:0] op, input logic [15:0] addr,
                             input logic [7:0] data, input logic [18:0] idx);
    access_t a;
    a = '{operation: op, address: addr, write_data: data, load_index: idx};
    while ($urandom_range(99) < send_idle_pct) begin
      access_ch.valid <= 1'b0;
      @(posedge clk);
    end
    access_ch.valid   <= 1'b1;
    access_ch.payload <= a;
    do @(posedge clk); while (!access_ch.ready);
    sb.note_access(a);
  endtask

  // ROM bytes that were never preloaded must not be read, so a read whose
  // physical byte is still unknown is preceded by a preload of that byte.
  task automatic read_rom(input logic [15:0] addr);
    int unsigned idx;
    idx = sb.rom_index(addr);
    if (!sb.rom_loaded(idx)) send_access(OP_PRELOAD, 16'($urandom), 8'($urandom), idx[18:0]);
    send_access(OP_READ, addr, 8'($urandom), 19'($urandom));
  endtask

  // Reads either window. Often it revisits a byte already loaded in the bank
  // that is mapped now, so that earlier preloads are checked through banking.
  task automatic random_rom_read();
    logic [15:0] base;
    logic [6:0]  bank;
    int          n;
    base = ($urandom_range(1) != 0) ? SWITCHED_BASE : 16'h0000;
    bank = sb.rom_bank(base);
    n = sb.bank_offsets[bank].size();
    if (n > 0 && $urandom_range(2) != 0)
      read_rom(base | {2'b00, sb.bank_offsets[bank][$urandom_range(n - 1)]});
    else
      read_rom(base | 16'($urandom_range(BANK_SPAN - 1)));
  endtask

  // Mostly well-formed cartridge traffic: banking register writes, ROM reads
  // through the current banks, RAM writes followed by reads of the same byte,
  // plus preloads anywhere, unmapped accesses and the unused opcode.
  task automatic run_random(input int count);
    int          pick;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [1:0]  op;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      data = 8'($urandom);
      if (pick < 15) begin
        addr = 16'($urandom_range(16'h7FFF));
        // Bias the enable register toward the unlock key so RAM is often open.
        if (reg_sel_t'(addr[14:13]) == REG_RAM_ENABLE && $urandom_range(99) < 65)
          data[3:0] = RAM_KEY;
        send_access(OP_WRITE, addr, data, 19'($urandom));
      end else if (pick < 45) begin
        random_rom_read();
      end else if (pick < 80) begin
        addr = ($urandom_range(1) != 0) ? recent_ram_addr : {RAM_WINDOW, 13'($urandom)};
        op = (pick < 62) ? OP_READ : OP_WRITE;
        if (op == OP_WRITE) recent_ram_addr = addr;
        send_access(op, addr, data, 19'($urandom));
      end else if (pick < 88) begin
        send_access(OP_PRELOAD, 16'($urandom), data, 19'($urandom));
      end else if (pick < 96) begin
        addr = ($urandom_range(1) != 0) ? {3'b100, 13'($urandom)}
                                        : 16'(16'hC000 + $urandom_range(16'h3FFF));
        op = ($urandom_range(1) != 0) ? OP_WRITE : OP_READ;
        send_access(op, addr, data, 19'($urandom));
      end else begin
        send_access(OP_UNUSED, 16'($urandom), data, 19'($urandom));
      end
    end
  endtask

  // Stops offering accesses and waits until every predicted byte has come
  // back, then lets the two-stage pipeline settle.
  task automatic drain();
    access_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write_t w;
    w = '{index: index, data: data};
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_config(w);
  endtask

  // Configuration only changes with the block idle.
  task automatic start_phase(input logic [6:0] mask, input logic [15:0] ram_bytes,
                             input int send_pct, input int recv_pct);
    drain();
    write_cfg(CFG_ROM_BANK_MASK, 16'(mask));
    write_cfg(CFG_RAM_SIZE_BYTES, ram_bytes);
    cfg_ch.valid <= 1'b0;
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    settings_used++;
  endtask

  initial begin
    rst = 1'b1;
    access_ch.valid   = 1'b0;
    access_ch.payload = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.payload    = '0;
    send_idle_pct     = 0;
    stall_pct         = 0;
    hold_request      = 0;
    settings_used     = 1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset configuration: two banks, no RAM. The
    // first access waits out the RAM clear that follows reset.
    send_access(OP_PRELOAD, 16'hFFFF, 8'h00, 19'h00000);
    send_access(OP_PRELOAD, 16'h0000, 8'hFF, 19'h7FFFF);
    read_rom(16'h0000);
    read_rom(16'h7FFF);
    // RAM window while RAM is both disabled and absent, then unmapped space.
    send_access(OP_READ, RAM_BASE, 8'hFF, 19'h7FFFF);
    send_access(OP_READ, 16'h8000, 8'h00, 19'h00000);
    send_access(OP_READ, 16'hFFFF, 8'h00, 19'h00000);
    send_access(OP_UNUSED, 16'hFFFF, 8'hFF, 19'h7FFFF);
    // Enabling RAM does not help when none is fitted.
    send_access(OP_WRITE, 16'h0000, 8'h0A, 19'h00000);
    send_access(OP_READ, 16'hBFFF, 8'h00, 19'h00000);
    // Low bank zero is read as bank one.
    send_access(OP_WRITE, 16'h2000, 8'h00, 19'h00000);
    read_rom(16'h4000);
    // All-ones writes to the low bank, upper bank and mode registers; only the low bits
    // stick and the narrow bank mask folds the result back into two banks.
    send_access(OP_WRITE, 16'h3FFF, 8'hFF, 19'h00000);
    send_access(OP_WRITE, 16'h5FFF, 8'hFF, 19'h00000);
    send_access(OP_WRITE, 16'h7FFF, 8'hFF, 19'h00000);
    read_rom(16'h3FFF);
    send_access(OP_WRITE, 16'hFFFF, 8'h5A, 19'h00000);
    send_access(OP_WRITE, RAM_BASE, 8'h5A, 19'h00000);

    // Widest setting: full bank mask and the largest RAM. In mode one with
    // upper bank three the top of the RAM window hits the last RAM byte.
    start_phase(7'h7F, 16'h8000, 0, 0);
    send_access(OP_WRITE, 16'h1FFF, 8'hFA, 19'h00000);
    send_access(OP_WRITE, 16'hBFFF, 8'hA5, 19'h00000);
    send_access(OP_READ, 16'hBFFF, 8'h00, 19'h00000);
    read_rom(16'h0000);
    read_rom(16'h7FFF);
    send_access(OP_WRITE, 16'h1000, 8'h0B, 19'h00000);
    send_access(OP_READ, 16'hBFFF, 8'h00, 19'h00000);
    send_access(OP_WRITE, 16'h6000, 8'hFE, 19'h00000);

    // Random part. In the first phase the receiver holds off for a long
    // stretch while accesses keep coming, so both pipeline stages fill and
    // the input stalls.
    run_random(40);
    hold_request = 80;
    run_random(80);
    start_phase(7'h01, 16'h0000, 77, 0);
    run_random(110);
    start_phase(7'h1F, 16'h2000, 0, 77);
    run_random(110);
    // A bank mask that is not one less than a power of two is a plain AND.
    start_phase(7'h05, 16'h0800, 9, 9);
    run_random(110);
    start_phase(7'h3F, 16'h0001, 0, 0);
    run_random(110);
    start_phase(7'h0F, 16'h7FFF, 9, 9);
    run_random(110);
    drain();

    $display("Ran %0d reads, %0d writes, %0d preloads and %0d unused-opcode accesses",
             sb.n_read, sb.n_write, sb.n_load, sb.n_unused);
    $display("under %0d cartridge settings; %0d results compared, %0d ROM bytes loaded.",
             settings_used, sb.compared, sb.rom_image.num());
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
